FILE: rtl/gslp_pkg.sv
// Package for the group straight-line program table evaluator.
// Holds opcodes, table numbers, status codes and sequencer types.
// No dependencies.
`default_nettype none
package gslp_pkg;

	localparam int ELEM_W = 8;
	localparam int SLOT_W = 10;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_CONST = 2'd1;
	localparam logic [1:0] OP_INV   = 2'd2;
	localparam logic [1:0] OP_MUL   = 2'd3;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_BADREF = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	localparam logic [1:0] MODE_RES   = 2'd1;
	localparam logic [1:0] MODE_OUTER = 2'd2;

	// load table id boundaries: flat tables, then exponent tables, then square tables
	localparam logic [4:0] ID_EXP_FIRST = 5'd9;
	localparam logic [4:0] ID_EXP_LAST  = 5'd10;
	localparam logic [4:0] ID_SQ_FIRST  = 5'd11;
	localparam logic [4:0] ID_SQ_END    = 5'd20;

	localparam int FLAT_DEPTH = 2304;
	localparam int EXP_DEPTH  = 1024;
	localparam int SQ_DEPTH   = 589824;

	// flat tables
	localparam logic [3:0] TF_LREP   = 4'd0;
	localparam logic [3:0] TF_LSUB   = 4'd1;
	localparam logic [3:0] TF_RREP   = 4'd2;
	localparam logic [3:0] TF_RSUB   = 4'd3;
	localparam logic [3:0] TF_INV    = 4'd4;
	localparam logic [3:0] TF_EXPO   = 4'd5;
	localparam logic [3:0] TF_RRES   = 4'd6;
	localparam logic [3:0] TF_LRES   = 4'd7;
	localparam logic [3:0] TF_SUBMAP = 4'd8;
	// exponent tables
	localparam logic TE_REXP = 1'b0;
	localparam logic TE_RRES = 1'b1;
	// square tables
	localparam logic [3:0] TS_HPROD  = 4'd0;
	localparam logic [3:0] TS_FLIPH  = 4'd1;
	localparam logic [3:0] TS_FLIPR  = 4'd2;
	localparam logic [3:0] TS_CROSSH = 4'd3;
	localparam logic [3:0] TS_CROSSR = 4'd4;
	localparam logic [3:0] TS_FUSE   = 4'd5;
	localparam logic [3:0] TS_NPROD  = 4'd6;
	localparam logic [3:0] TS_NFLIP  = 4'd7;
	localparam logic [3:0] TS_NFUSE  = 4'd8;

	typedef enum logic [5:0] {
		S_IDLE, S_VA, S_VB,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
		S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7, S_R8, S_R9, S_R10,
		S_O0, S_O1, S_O2, S_O3, S_O4, S_O5, S_O6, S_O7, S_O8, S_O9, S_O10,
		S_O11, S_O12, S_O13,
		S_CAP, S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {PH_RES, PH_OUT1, PH_OUT2} phase_t;

	typedef enum logic [2:0] {LK_NONE, LK_VS, LK_FL, LK_EX, LK_SQ} lk_kind_t;

endpackage
`default_nettype wire

FILE: rtl/gslp_if.sv
// Valid/ready channel interfaces: program/load items, results, mode register writes.
// Standalone; no package needed.
`default_nettype none
interface gslp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic       first;
	logic [9:0] operand_a;
	logic [9:0] operand_b;
	logic [4:0] table_id;
	logic [8:0] table_row;
	logic [7:0] table_col;
	logic [7:0] entry_value;
	modport source (output valid, op, first, operand_a, operand_b, table_id, table_row,
		table_col, entry_value, input ready);
	modport sink (input valid, op, first, operand_a, operand_b, table_id, table_row,
		table_col, entry_value, output ready);
endinterface

interface gslp_rsp_if;
	logic       valid;
	logic       ready;
	logic [9:0] slot;
	logic [7:0] element;
	logic [1:0] status;
	modport source (output valid, slot, element, status, input ready);
	modport sink (input valid, slot, element, status, output ready);
endinterface

interface gslp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] multiply_mode;
	modport source (output valid, multiply_mode, input ready);
	modport sink (input valid, multiply_mode, output ready);
endinterface
`default_nettype wire

FILE: rtl/group_slp_table_evaluator_core.sv
// Group straight-line program evaluator: table memories, value store, lookup sequencer.
// Depends on gslp_pkg and the channel interfaces in gslp_if.sv.
// Constant, bad reference and full items are answered directly; inverse and multiply
// (direct, residue, outer) run through the sequencer as a chain of dependent table reads.
// Load items take no result and are accepted every cycle while ready is high.
// One program item at a time; ready is low while the sequencer runs or a result is
// stalled. arst_n clears sequencer, slot counter, mode and output valid; tables and
// value store are not cleared.
`default_nettype none
module group_slp_table_evaluator_core import gslp_pkg::*; #(
	parameter int PROGRAM_SLOTS = 1024
) (
	input  wire        clk,
	input  wire        arst_n,
	gslp_req_if.sink   req,
	gslp_rsp_if.source rsp,
	gslp_cfg_if.sink   cfg
);

	localparam int AW   = $clog2(PROGRAM_SLOTS);
	localparam int SW   = $clog2(PROGRAM_SLOTS + 1);
	localparam int CMPW = (SW > SLOT_W) ? SW : SLOT_W;
	localparam logic [CMPW-1:0] SLOTS_W = CMPW'(PROGRAM_SLOTS);

	seq_state_t state_q, state_d;
	phase_t     phase_q;
	lk_kind_t   kind, kind_q;
	logic [1:0] mode_q;
	logic       inv_q;
	logic [SW-1:0] cnt_q;

	logic        out_v_q;
	logic [9:0]  out_slot_q;
	logic [7:0]  out_elem_q;
	logic [1:0]  out_stat_q;

	logic [7:0] x_q, y_q, u_q, v_q, cl_q, sl_q, r1_q, r2_q;
	logic [7:0] h1_q, h2_q, h3_q, r3_q, ex_q, ey_q, rx_q, n2_q, g_q, res_q;
	logic [AW-1:0] b_q;

	logic [7:0] vs_mem [0:PROGRAM_SLOTS-1];
	logic [7:0] fl_mem [0:FLAT_DEPTH-1];
	logic [7:0] ex_mem [0:EXP_DEPTH-1];
	logic [7:0] sq_mem [0:SQ_DEPTH-1];
	logic [7:0] vs_rd_q, fl_rd_q, ex_rd_q, sq_rd_q, d;

	logic [AW-1:0] vs_raddr, vs_waddr;
	logic [3:0]    fl_t, sq_t;
	logic [7:0]    fl_i, sq_r, sq_c;
	logic          ex_t;
	logic [8:0]    ex_s, esum;

	logic            acc, prog, is_load, full, bad, imm, done_go, out_load, vs_we;
	logic [SW-1:0]   cnt_eff;
	logic [CMPW-1:0] cnt_w, cnt_qw, a_w, b_w;
	logic            fl_we, ex_we, sq_we;
	logic [4:0]      sq_id;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE) && (!out_v_q || rsp.ready);
	assign rsp.valid   = out_v_q;
	assign rsp.slot    = out_slot_q;
	assign rsp.element = out_elem_q;
	assign rsp.status  = out_stat_q;

	assign acc     = req.valid && req.ready;
	assign is_load = (req.op == OP_LOAD);
	assign prog    = acc && !is_load;
	assign cnt_eff = req.first ? '0 : cnt_q;
	assign cnt_w   = CMPW'(cnt_eff);
	assign cnt_qw  = CMPW'(cnt_q);
	assign a_w     = CMPW'(req.operand_a);
	assign b_w     = CMPW'(req.operand_b);
	assign full    = cnt_w >= SLOTS_W;
	assign bad     = (((req.op == OP_INV) || (req.op == OP_MUL)) && (a_w >= cnt_w))
		|| ((req.op == OP_MUL) && (b_w >= cnt_w));
	assign imm      = prog && (full || bad || (req.op == OP_CONST));
	assign done_go  = (state_q == S_DONE) && (!out_v_q || rsp.ready);
	assign out_load = imm || done_go;
	assign vs_we    = (prog && !full && !bad && (req.op == OP_CONST)) || done_go;
	assign vs_waddr = done_go ? cnt_q[AW-1:0] : cnt_eff[AW-1:0];
	assign esum     = {1'b0, ex_q} + {1'b0, ey_q};

	// load decode
	assign sq_id = req.table_id - ID_SQ_FIRST;
	assign fl_we = acc && is_load && (req.table_id < ID_EXP_FIRST) && !req.table_row[8];
	assign ex_we = acc && is_load && (req.table_id >= ID_EXP_FIRST)
		&& (req.table_id <= ID_EXP_LAST);
	assign sq_we = acc && is_load && (req.table_id >= ID_SQ_FIRST)
		&& (req.table_id < ID_SQ_END) && !req.table_row[8];

	// memories
	always_ff @(posedge clk) begin
		if (vs_we) begin
			vs_mem[vs_waddr] <= done_go ? res_q : req.operand_a[7:0];
		end
		vs_rd_q <= vs_mem[vs_raddr];
	end

	always_ff @(posedge clk) begin
		if (fl_we) begin
			fl_mem[{req.table_id[3:0], req.table_row[7:0]}] <= req.entry_value;
		end
		fl_rd_q <= fl_mem[{fl_t, fl_i}];
	end

	always_ff @(posedge clk) begin
		if (ex_we) begin
			ex_mem[{(req.table_id == ID_EXP_LAST), req.table_row}] <= req.entry_value;
		end
		ex_rd_q <= ex_mem[{ex_t, ex_s}];
	end

	always_ff @(posedge clk) begin
		if (sq_we) begin
			sq_mem[{sq_id[3:0], req.table_row[7:0], req.table_col}] <= req.entry_value;
		end
		sq_rd_q <= sq_mem[{sq_t, sq_r, sq_c}];
	end

	always_comb begin
		case (kind_q)
			LK_VS:   d = vs_rd_q;
			LK_FL:   d = fl_rd_q;
			LK_EX:   d = ex_rd_q;
			LK_SQ:   d = sq_rd_q;
			default: d = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (prog && !imm) state_d = S_VA;
			S_VA:   state_d = inv_q ? S_CAP : S_VB;
			S_VB: begin
				if (mode_q == MODE_OUTER) state_d = S_O0;
				else if (mode_q == MODE_RES) state_d = S_R0;
				else state_d = S_M0;
			end
			S_M0: state_d = S_M1;
			S_M1: state_d = S_M2;
			S_M2: state_d = S_M3;
			S_M3: state_d = S_M4;
			S_M4: state_d = S_M5;
			S_M5: state_d = S_M6;
			S_M6: state_d = S_M7;
			S_M7: state_d = S_M8;
			S_M8: state_d = S_M9;
			S_M9: state_d = S_CAP;
			S_R0: state_d = S_R1;
			S_R1: state_d = S_R2;
			S_R2: state_d = S_R3;
			S_R3: state_d = S_R4;
			S_R4: state_d = S_R5;
			S_R5: state_d = S_R6;
			S_R6: state_d = S_R7;
			S_R7: state_d = S_R8;
			S_R8: state_d = S_R9;
			S_R9: state_d = (phase_q == PH_RES) ? S_CAP : S_R10;
			S_R10: state_d = (phase_q == PH_OUT1) ? S_O5 : S_O13;
			S_O0:  state_d = S_O1;
			S_O1:  state_d = S_O2;
			S_O2:  state_d = S_O3;
			S_O3:  state_d = S_O4;
			S_O4:  state_d = S_R0;
			S_O5:  state_d = S_O6;
			S_O6:  state_d = S_O7;
			S_O7:  state_d = S_O8;
			S_O8:  state_d = S_O9;
			S_O9:  state_d = S_O10;
			S_O10: state_d = S_O11;
			S_O11: state_d = S_O12;
			S_O12: state_d = S_R0;
			S_O13: state_d = S_CAP;
			S_CAP: state_d = S_DONE;
			S_DONE: if (done_go) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// lookup request issued in each sequencer state; some states issue none
	always_comb begin
		kind     = LK_NONE;
		vs_raddr = b_q;
		fl_t = TF_LREP; fl_i = x_q;
		ex_t = TE_REXP; ex_s = esum;
		sq_t = TS_HPROD; sq_r = d; sq_c = d;
		case (state_q)
			S_IDLE: begin kind = LK_VS; vs_raddr = a_w[AW-1:0]; end
			S_VA: begin
				if (inv_q) begin kind = LK_FL; fl_t = TF_INV; fl_i = d; end
				else kind = LK_VS;
			end
			S_VB, S_M0: begin
				kind = LK_FL; fl_i = x_q;
				fl_t = (state_q == S_VB) ? TF_LREP : TF_LSUB;
			end
			S_M1: begin kind = LK_FL; fl_t = TF_RREP; fl_i = y_q; end
			S_M2: begin kind = LK_FL; fl_t = TF_RSUB; fl_i = y_q; end
			S_M3: begin kind = LK_SQ; sq_t = TS_HPROD; sq_r = sl_q; sq_c = d; end
			S_M4: begin kind = LK_SQ; sq_t = TS_FLIPH; sq_r = cl_q; sq_c = d; end
			S_M5: begin kind = LK_SQ; sq_t = TS_FLIPR; sq_r = cl_q; sq_c = h1_q; end
			S_M6: begin kind = LK_SQ; sq_t = TS_CROSSH; sq_r = d; sq_c = r2_q; end
			S_M7: begin kind = LK_SQ; sq_t = TS_CROSSR; sq_r = r1_q; sq_c = r2_q; end
			S_M8: begin kind = LK_SQ; sq_t = TS_HPROD; sq_r = h2_q; sq_c = h3_q; end
			S_M9: begin kind = LK_SQ; sq_t = TS_FUSE; sq_r = d; sq_c = r3_q; end
			S_R0: begin kind = LK_FL; fl_t = TF_EXPO; fl_i = u_q; end
			S_R1: begin kind = LK_FL; fl_t = TF_EXPO; fl_i = v_q; end
			S_R2: begin kind = LK_FL; fl_t = TF_RRES; fl_i = u_q; end
			S_R3: begin kind = LK_FL; fl_t = TF_LRES; fl_i = v_q; end
			S_R4: begin kind = LK_SQ; sq_t = TS_NPROD; sq_r = rx_q; sq_c = d; end
			S_R5: begin kind = LK_SQ; sq_t = TS_NFLIP; sq_r = d; sq_c = ey_q; end
			S_R6: begin kind = LK_EX; ex_t = TE_REXP; end
			S_R7: begin kind = LK_EX; ex_t = TE_RRES; end
			S_R8: begin kind = LK_SQ; sq_t = TS_NPROD; sq_r = d; sq_c = n2_q; end
			S_R9: begin kind = LK_SQ; sq_t = TS_NFUSE; sq_r = g_q; sq_c = d; end
			S_R10: begin kind = LK_FL; fl_t = TF_RSUB; fl_i = d; end
			S_O0: begin kind = LK_FL; fl_t = TF_LSUB; fl_i = x_q; end
			S_O1: begin kind = LK_FL; fl_t = TF_SUBMAP; fl_i = d; end
			S_O2: begin kind = LK_FL; fl_t = TF_RSUB; fl_i = y_q; end
			S_O3: begin kind = LK_FL; fl_t = TF_SUBMAP; fl_i = d; end
			S_O5: begin kind = LK_SQ; sq_t = TS_FLIPH; sq_r = cl_q; sq_c = d; end
			S_O6: begin kind = LK_SQ; sq_t = TS_FLIPR; sq_r = cl_q; sq_c = h1_q; end
			S_O7: begin kind = LK_FL; fl_t = TF_RREP; fl_i = y_q; end
			S_O8: begin kind = LK_SQ; sq_t = TS_CROSSH; sq_r = r1_q; sq_c = d; end
			S_O9: begin kind = LK_SQ; sq_t = TS_CROSSR; sq_r = r1_q; sq_c = r2_q; end
			S_O10: begin kind = LK_FL; fl_t = TF_SUBMAP; fl_i = h2_q; end
			S_O11: begin kind = LK_FL; fl_t = TF_SUBMAP; fl_i = h3_q; end
			S_O13: begin kind = LK_SQ; sq_t = TS_FUSE; sq_r = d; sq_c = r3_q; end
			default: kind = LK_NONE;
		endcase
	end

	// capture lookup results into working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_VA:  begin x_q <= d; u_q <= d; end
			S_VB:  begin y_q <= d; v_q <= d; end
			S_M0, S_O0: cl_q <= d;
			S_M1:  sl_q <= d;
			S_M2, S_O8: r2_q <= d;
			S_M4, S_O5: h1_q <= d;
			S_M5, S_O6: h2_q <= d;
			S_M6, S_O7: r1_q <= d;
			S_M7, S_O9: h3_q <= d;
			S_M8, S_O10: r3_q <= d;
			S_R1:  ex_q <= d;
			S_R2:  ey_q <= d;
			S_R3:  rx_q <= d;
			S_R6:  n2_q <= d;
			S_R7:  g_q <= d;
			S_O2, S_O11: u_q <= d;
			S_O4, S_O12: v_q <= d;
			S_CAP: res_q <= d;
			default: ;
		endcase
		// hold the second operand slot; the input bus may move after accept
		if (acc) b_q <= b_w[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (done_go) begin
				out_slot_q <= cnt_qw[SLOT_W-1:0];
				out_elem_q <= res_q;
				out_stat_q <= STAT_OK;
			end else if (full) begin
				out_slot_q <= '0;
				out_elem_q <= '0;
				out_stat_q <= STAT_FULL;
			end else if (bad) begin
				out_slot_q <= cnt_w[SLOT_W-1:0];
				out_elem_q <= '0;
				out_stat_q <= STAT_BADREF;
			end else begin
				out_slot_q <= cnt_w[SLOT_W-1:0];
				out_elem_q <= req.operand_a[7:0];
				out_stat_q <= STAT_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_RES;
			kind_q  <= LK_NONE;
			mode_q  <= '0;
			inv_q   <= 1'b0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind;
			if (cfg.valid) mode_q <= cfg.multiply_mode;
			if (acc) inv_q <= (req.op == OP_INV);
			if (state_q == S_VB) phase_q <= PH_RES;
			if (state_q == S_O4) phase_q <= PH_OUT1;
			if (state_q == S_O12) phase_q <= PH_OUT2;
			if (prog) begin
				cnt_q <= (!full && !bad && (req.op == OP_CONST)) ? cnt_eff + 1'b1 : cnt_eff;
			end else if (done_go) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/gslp_checker.sv
// Port-level checks on the evaluator's result channel and handshake.
// Bound to group_slp_table_evaluator_core; uses gslp_pkg status codes.
`default_nettype none
module gslp_checker import gslp_pkg::*; (
	input wire       clk,
	input wire       arst_n,
	input wire       req_valid,
	input wire       req_ready,
	input wire       rsp_valid,
	input wire       rsp_ready,
	input wire [9:0] rsp_slot,
	input wire [7:0] rsp_element,
	input wire [1:0] rsp_status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot)
		&& $stable(rsp_element) && $stable(rsp_status))
		else $error("result changed while stalled");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STAT_FULL) |-> (rsp_slot == '0) && (rsp_element == '0))
		else $error("full status with nonzero slot or element");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STAT_BADREF) |-> (rsp_element == '0))
		else $error("bad reference with nonzero element");

	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("item taken while result stalled");

endmodule

bind group_slp_table_evaluator_core gslp_checker u_gslp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_slot    (rsp.slot),
	.rsp_element (rsp.element),
	.rsp_status  (rsp.status)
);
`default_nettype wire

FILE: dv/tb_group_slp_table_evaluator_core.sv
// Testbench for group_slp_table_evaluator_core: loads closed lookup tables, runs programs.
// Predicts every result in-line and checks it. Depends on gslp_pkg and gslp_if.sv.
`default_nettype none
module tb_group_slp_table_evaluator_core;
	import gslp_pkg::*;

	localparam logic [1:0] MODE_DIRECT = 2'd0;
	localparam logic [1:0] MODE_RSVD   = 2'd3;
	localparam int SLOTS       = 1024;
	localparam int IDLE_LIMIT  = 3000;
	localparam int SETTLE      = 60;
	localparam int RAND_PHASES = 4;
	localparam int PHASE_ITEMS = 40;
	// elements the tables map onto each other; together they toggle every bit
	localparam bit [7:0] ELEMS [4] = '{8'h00, 8'h55, 8'hAA, 8'hFF};

	typedef struct {
		logic [1:0] op;
		logic       first;
		logic [9:0] a;
		logic [9:0] b;
		logic [4:0] tid;
		logic [8:0] row;
		logic [7:0] col;
		logic [7:0] val;
	} gslp_item_t;

	typedef struct {
		logic [9:0] slot;
		logic [7:0] element;
		logic [1:0] status;
	} gslp_res_t;

	logic clk;
	logic arst_n;
	gslp_req_if req_if ();
	gslp_rsp_if rsp_if ();
	gslp_cfg_if cfg_if ();

	group_slp_table_evaluator_core #(.PROGRAM_SLOTS(SLOTS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	bit [7:0] flat_t [0:9*256-1];
	bit [7:0] exp_t [0:2*512-1];
	bit [7:0] sq_t [int];
	bit [7:0] vstore [0:SLOTS-1];
	int prog_cnt;
	logic [1:0] mode_r;
	gslp_res_t expected_q [$];
	int errors;
	int idle_cnt;
	int long_hold;
	bit no_gap;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic bit [7:0] rd_flat(logic [3:0] t, int i);
		return flat_t[int'(t) * 256 + i % 256];
	endfunction

	function automatic bit [7:0] rd_exp(logic t, int i);
		return exp_t[int'(t) * 512 + i % 512];
	endfunction

	function automatic bit [7:0] rd_sq(logic [3:0] t, int r, int c);
		int key;
		key = int'(t) * 65536 + (r % 256) * 256 + c % 256;
		return sq_t.exists(key) ? sq_t[key] : 8'h00;
	endfunction

	function automatic bit [7:0] mul_dir(bit [7:0] x, bit [7:0] y);
		bit [7:0] cl, sl, r2, sy, h1, h2, r1, h3, r3, h4;
		cl = rd_flat(TF_LREP, x);
		sl = rd_flat(TF_LSUB, x);
		r2 = rd_flat(TF_RREP, y);
		sy = rd_flat(TF_RSUB, y);
		h1 = rd_sq(TS_HPROD, sl, sy);
		h2 = rd_sq(TS_FLIPH, cl, h1);
		r1 = rd_sq(TS_FLIPR, cl, h1);
		h3 = rd_sq(TS_CROSSH, r1, r2);
		r3 = rd_sq(TS_CROSSR, r1, r2);
		h4 = rd_sq(TS_HPROD, h2, h3);
		return rd_sq(TS_FUSE, h4, r3);
	endfunction

	function automatic bit [7:0] mul_res(bit [7:0] x, bit [7:0] y);
		bit [7:0] ex, ey, rx, ly, n1, n2, g, rn, n3;
		int sum;
		ex = rd_flat(TF_EXPO, x);
		ey = rd_flat(TF_EXPO, y);
		rx = rd_flat(TF_RRES, x);
		ly = rd_flat(TF_LRES, y);
		n1 = rd_sq(TS_NPROD, rx, ly);
		n2 = rd_sq(TS_NFLIP, n1, ey);
		sum = int'(ex) + int'(ey);
		g = rd_exp(TE_REXP, sum);
		rn = rd_exp(TE_RRES, sum);
		n3 = rd_sq(TS_NPROD, rn, n2);
		return rd_sq(TS_NFUSE, g, n3);
	endfunction

	function automatic bit [7:0] mul_out(bit [7:0] x, bit [7:0] y);
		bit [7:0] cl, sl, sy, r2, p, h1, h2, r1, h3, r3, q, h4;
		cl = rd_flat(TF_LREP, x);
		sl = rd_flat(TF_LSUB, x);
		sy = rd_flat(TF_RSUB, y);
		r2 = rd_flat(TF_RREP, y);
		p = mul_res(rd_flat(TF_SUBMAP, sl), rd_flat(TF_SUBMAP, sy));
		h1 = rd_flat(TF_RSUB, p);
		h2 = rd_sq(TS_FLIPH, cl, h1);
		r1 = rd_sq(TS_FLIPR, cl, h1);
		h3 = rd_sq(TS_CROSSH, r1, r2);
		r3 = rd_sq(TS_CROSSR, r1, r2);
		q = mul_res(rd_flat(TF_SUBMAP, h2), rd_flat(TF_SUBMAP, h3));
		h4 = rd_flat(TF_RSUB, q);
		return rd_sq(TS_FUSE, h4, r3);
	endfunction

	// update tables / value store for one accepted item; queue its result
	function automatic void predict_item(gslp_item_t it);
		gslp_res_t res;
		bit [7:0] x, y;
		if (it.op == OP_LOAD) begin
			if (it.tid < ID_EXP_FIRST) begin
				if (it.row < 256) flat_t[int'(it.tid) * 256 + it.row] = it.val;
			end else if (it.tid <= ID_EXP_LAST) begin
				exp_t[int'(it.tid - ID_EXP_FIRST) * 512 + it.row] = it.val;
			end else if (it.tid < ID_SQ_END) begin
				if (it.row < 256)
					sq_t[int'(it.tid - ID_SQ_FIRST) * 65536 + int'(it.row) * 256 + it.col] = it.val;
			end
			return;
		end
		if (it.first) prog_cnt = 0;
		res.slot = prog_cnt[9:0];
		res.element = 8'h00;
		res.status = STAT_OK;
		if (prog_cnt >= SLOTS) begin
			res.slot = 10'd0;
			res.status = STAT_FULL;
		end else if ((it.op != OP_CONST && it.a >= prog_cnt) ||
				(it.op == OP_MUL && it.b >= prog_cnt)) begin
			res.status = STAT_BADREF;
		end else begin
			x = vstore[it.a];
			y = vstore[it.b];
			case (it.op)
				OP_CONST: res.element = it.a[7:0];
				OP_INV: res.element = rd_flat(TF_INV, x);
				default: begin
					if (mode_r == MODE_RES) res.element = mul_res(x, y);
					else if (mode_r == MODE_OUTER) res.element = mul_out(x, y);
					else res.element = mul_dir(x, y);
				end
			endcase
			vstore[prog_cnt] = res.element;
			prog_cnt++;
		end
		expected_q = {expected_q, res};
	endfunction

	function automatic int draw_gap();
		return no_gap ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic bit [7:0] pick_elem();
		return ELEMS[$urandom_range(0, 3)];
	endfunction

	function automatic gslp_item_t mk_prog(logic [1:0] op, logic first, int a, int b);
		gslp_item_t it;
		it.op = op;
		it.first = first;
		it.a = a[9:0];
		it.b = b[9:0];
		it.tid = 5'($urandom);
		it.row = 9'($urandom);
		it.col = 8'($urandom);
		it.val = 8'($urandom);
		return it;
	endfunction

	function automatic gslp_item_t mk_load(int tid, int row, int col, int val);
		gslp_item_t it;
		it.op = OP_LOAD;
		it.first = 1'($urandom);
		it.a = 10'($urandom);
		it.b = 10'($urandom);
		it.tid = tid[4:0];
		it.row = row[8:0];
		it.col = col[7:0];
		it.val = val[7:0];
		return it;
	endfunction

	task automatic send_item(gslp_item_t it);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.op <= it.op;
		req_if.first <= it.first;
		req_if.operand_a <= it.a;
		req_if.operand_b <= it.b;
		req_if.table_id <= it.tid;
		req_if.table_row <= it.row;
		req_if.table_col <= it.col;
		req_if.entry_value <= it.val;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (!req_if.ready);
		predict_item(it);
	endtask

	task automatic send_prog(logic [1:0] op, logic first, int a, int b);
		send_item(mk_prog(op, first, a, b));
	endtask

	// drop valid, let every result drain, then give the sequencer time to go idle
	task automatic drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_mode(logic [1:0] m);
		drain();
		cfg_if.multiply_mode <= m;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		mode_r = m;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// rewrite one table entry that lookups can reach, value kept inside the element set
	task automatic reload_entry();
		int kind;
		kind = $urandom_range(0, 2);
		if (kind == 0)
			send_item(mk_load($urandom_range(0, ID_EXP_FIRST - 1), pick_elem(), $urandom,
				pick_elem()));
		else if (kind == 1)
			send_item(mk_load($urandom_range(ID_EXP_FIRST, ID_EXP_LAST),
				int'(pick_elem()) + int'(pick_elem()), $urandom, pick_elem()));
		else
			send_item(mk_load($urandom_range(ID_SQ_FIRST, ID_SQ_END - 1), pick_elem(),
				pick_elem(), pick_elem()));
	endtask

	task automatic test_load_tables();
		for (int t = 0; t < ID_EXP_FIRST; t++)
			for (int i = 0; i < 4; i++)
				send_item(mk_load(t, ELEMS[i], $urandom, pick_elem()));
		for (int t = ID_EXP_FIRST; t <= ID_EXP_LAST; t++)
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					send_item(mk_load(t, int'(ELEMS[i]) + int'(ELEMS[j]), $urandom,
						pick_elem()));
		for (int t = ID_SQ_FIRST; t < ID_SQ_END; t++)
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					send_item(mk_load(t, ELEMS[i], ELEMS[j], pick_elem()));
	endtask

	task automatic test_directed();
		send_prog(OP_CONST, 1'b1, 10'h000, 10'h3FF);
		send_prog(OP_CONST, 1'b0, 10'h3FF, 10'h000);
		send_prog(OP_CONST, 1'b0, 10'h155, 10'h000);
		send_prog(OP_CONST, 1'b0, 10'h2AA, 10'h000);
		send_prog(OP_INV, 1'b0, 0, 0);
		send_prog(OP_INV, 1'b0, 3, 0);
		send_prog(OP_MUL, 1'b0, 0, 1);
		send_prog(OP_MUL, 1'b0, 3, 2);
		// bad references: operand at and beyond the counter
		send_prog(OP_INV, 1'b0, 1023, 0);
		send_prog(OP_MUL, 1'b0, 0, prog_cnt);
		send_prog(OP_MUL, 1'b0, prog_cnt, 0);
		send_prog(OP_INV, 1'b1, 0, 0);
		send_prog(OP_CONST, 1'b0, 10'h0AA, 10'h000);
		// ignored loads (id past the last table, rows past a table's extent), then loads to a table's last row
		send_item(mk_load(31, 0, 0, 8'h00));
		send_item(mk_load(ID_SQ_END, ELEMS[1], ELEMS[2], 8'hA5));
		send_item(mk_load(TF_INV, 300, 0, 8'h5A));
		send_item(mk_load(ID_SQ_FIRST, 511, 255, 8'h3C));
		send_item(mk_load(ID_EXP_LAST, 511, 255, 8'hC3));
		send_item(mk_load(ID_SQ_END - 1, 255, 255, pick_elem()));
		send_prog(OP_INV, 1'b0, 0, 0);
		send_prog(OP_MUL, 1'b0, 1, 0);
	endtask

	task automatic test_modes();
		logic [1:0] modes [4] = '{MODE_RES, MODE_OUTER, MODE_RSVD, MODE_DIRECT};
		foreach (modes[k]) begin
			write_mode(modes[k]);
			send_prog(OP_CONST, 1'b1, pick_elem(), 0);
			send_prog(OP_CONST, 1'b0, pick_elem(), 0);
			send_prog(OP_MUL, 1'b0, 0, 1);
			send_prog(OP_MUL, 1'b0, 2, 2);
			send_prog(OP_INV, 1'b0, 3, 0);
		end
	endtask

	task automatic rand_prog();
		int r, cnt;
		logic first;
		r = $urandom_range(0, 99);
		first = ($urandom_range(0, 39) == 0);
		cnt = first ? 0 : prog_cnt;
		if (r < 8 && cnt < SLOTS) begin
			if ($urandom_range(0, 1))
				send_prog(OP_INV, first, $urandom_range(cnt, 1023), $urandom);
			else if (cnt > 0 && $urandom_range(0, 1))
				send_prog(OP_MUL, first, $urandom_range(0, cnt - 1), $urandom_range(cnt, 1023));
			else
				send_prog(OP_MUL, first, $urandom_range(cnt, 1023), $urandom);
		end else if (cnt == 0 || r < 30) begin
			send_prog(OP_CONST, first, int'({2'($urandom_range(0, 3)), pick_elem()}),
				$urandom);
		end else if (r < 50) begin
			send_prog(OP_INV, first, $urandom_range(0, cnt - 1), $urandom);
		end else begin
			send_prog(OP_MUL, first, $urandom_range(0, cnt - 1), $urandom_range(0, cnt - 1));
		end
	endtask

	task automatic test_random();
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			write_mode(2'($urandom_range(0, 3)));
			no_gap = (ph == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) == 0) reload_entry();
				if ($urandom_range(0, 29) == 0)
					send_item(mk_load($urandom, $urandom, $urandom, pick_elem()));
				rand_prog();
			end
			no_gap = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		write_mode(MODE_OUTER);
		long_hold = 300;
		send_prog(OP_CONST, 1'b1, pick_elem(), 0);
		for (int n = 0; n < 12; n++) send_prog(OP_MUL, 1'b0, $urandom_range(0, prog_cnt - 1), 0);
		drain();
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int n;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				n = long_hold;
				long_hold = 0;
			end else begin
				n = draw_gap();
			end
			if (n > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	always @(posedge clk) begin
		gslp_res_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result slot %0d element %h status %0d", $time,
					rsp_if.slot, rsp_if.element, rsp_if.status);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (rsp_if.slot !== e.slot) begin
					$display("%0t slot exp %0d act %0d", $time, e.slot, rsp_if.slot);
					errors++;
				end
				if (rsp_if.element !== e.element) begin
					$display("%0t element exp %h act %h", $time, e.element, rsp_if.element);
					errors++;
				end
				if (rsp_if.status !== e.status) begin
					$display("%0t status exp %0d act %0d", $time, e.status, rsp_if.status);
					errors++;
				end
			end
		end
	end

	// end the run if nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cnt = 0;
		long_hold = 0;
		no_gap = 1'b0;
		prog_cnt = 0;
		mode_r = MODE_DIRECT;
		req_if.valid = 1'b0;
		req_if.op = OP_LOAD;
		req_if.first = 1'b0;
		req_if.operand_a = '0;
		req_if.operand_b = '0;
		req_if.table_id = '0;
		req_if.table_row = '0;
		req_if.table_col = '0;
		req_if.entry_value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.multiply_mode = MODE_DIRECT;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_load_tables();
		test_directed();
		test_modes();
		test_random();
		test_backpressure();
		drain();

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
